### sv/lcdmts_pkg.sv
// Shared types, register indexes and reset values for the LCD mode timing sequencer.
// No dependencies; used by lcdmts_step and lcd_mode_timing_sequencer.
`default_nettype none

package lcdmts_pkg;

    localparam int VISIBLE_LINES_DEF = 144;
    localparam int TOTAL_LINES_DEF   = 154;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int ACCUM_W     = 11;
    localparam int THR_W       = 10;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    localparam logic [CFG_INDEX_W-1:0] REG_LCD_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STAT_ENABLES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OAM_CYCLES    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DRAW_CYCLES   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_CYCLES = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_CYCLES   = 3'd6;

    // status source enable bits
    localparam int STAT_HBLANK = 0;
    localparam int STAT_VBLANK = 1;
    localparam int STAT_OAM    = 2;
    localparam int STAT_MATCH  = 3;

    localparam logic [THR_W-1:0]   OAM_CYCLES_RST    = 10'd80;
    localparam logic [THR_W-1:0]   DRAW_CYCLES_RST   = 10'd172;
    localparam logic [THR_W-1:0]   HBLANK_CYCLES_RST = 10'd204;
    localparam logic [THR_W-1:0]   LINE_CYCLES_RST   = 10'd456;
    localparam logic [7:0]         LINE_RST          = 8'd144;
    localparam logic [ACCUM_W-1:0] ACCUM_MAX         = 11'h7FF;

    typedef struct packed {
        logic             enable;
        logic [7:0]       line_compare;
        logic [3:0]       stat_enables;
        logic [THR_W-1:0] oam_cycles;
        logic [THR_W-1:0] draw_cycles;
        logic [THR_W-1:0] hblank_cycles;
        logic [THR_W-1:0] line_cycles;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [7:0]         line;
        logic [ACCUM_W-1:0] accum;
        logic               irq_level;
        logic               frame_pending;
    } state_t;

    typedef struct packed {
        logic         line_rendered;
        logic         frame_new;
        logic         stat_irq;
        logic         vblank_irq;
        logic         line_match;
        logic [7:0]   line;
        mode_t        mode;
    } result_t;

endpackage

`default_nettype wire

### sv/lcd_mode_timing_sequencer.sv
// Top level of the LCD mode timing sequencer: stream ports, configuration registers,
// state and result registers. Depends on lcdmts_pkg and lcdmts_step.
//
// Each input transfer is one tick carrying elapsed cycles; the block adds them to an
// 11-bit saturating accumulator and makes at most one mode transition (OAM scan, draw,
// horizontal blank, next line, vertical blank, wrap), then returns one result transfer
// with mode, line, line-compare match and the interrupt and strobe flags. The state
// update is a single compare-and-subtract between the state registers and the result
// register, so a tick is accepted every cycle while the result register is empty or
// being drained and no configuration write is offered.
// Configuration writes are always ready and take precedence over ticks; writing
// lcd_enable low while it is high forces line 0, horizontal blank, clears the
// accumulator and the pending frame flag. Ticks while disabled change nothing but the
// frame acknowledge.
`default_nettype none

module lcd_mode_timing_sequencer #(
    parameter int VISIBLE_LINES = lcdmts_pkg::VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES   = lcdmts_pkg::TOTAL_LINES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    // [7:0] cycles, [8] frame_ack, [15:9] zero
    input  wire logic [15:0]                        s_tdata,
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    // [1:0] mode, [9:2] line, [10] line_match, [11] vblank_irq, [12] stat_irq,
    // [13] frame_new, [14] line_rendered, [15] zero
    output      logic [15:0]                        m_tdata,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [lcdmts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lcdmts_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [8:0] VIS_LINES = 9'(VISIBLE_LINES);

    lcdmts_pkg::cfg_t    cfg_reg;
    lcdmts_pkg::state_t  st_reg;
    lcdmts_pkg::state_t  st_next;
    lcdmts_pkg::result_t res_next;
    lcdmts_pkg::result_t res_reg;
    logic                out_valid_reg;
    logic                in_xfer;
    logic                cfg_xfer;

    // hold ticks off while a register write is offered
    assign s_tready  = (!out_valid_reg || m_tready) && !cfg_valid;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, res_reg};

    lcdmts_step #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_step (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .cycles    (s_tdata[7:0]),
        .frame_ack (s_tdata[8]),
        .st_next   (st_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b1;
            cfg_reg.line_compare  <= 8'd0;
            cfg_reg.stat_enables  <= 4'd0;
            cfg_reg.oam_cycles    <= lcdmts_pkg::OAM_CYCLES_RST;
            cfg_reg.draw_cycles   <= lcdmts_pkg::DRAW_CYCLES_RST;
            cfg_reg.hblank_cycles <= lcdmts_pkg::HBLANK_CYCLES_RST;
            cfg_reg.line_cycles   <= lcdmts_pkg::LINE_CYCLES_RST;
            st_reg.mode           <= lcdmts_pkg::MODE_VBLANK;
            st_reg.line           <= lcdmts_pkg::LINE_RST;
            st_reg.accum          <= '0;
            st_reg.irq_level      <= 1'b0;
            st_reg.frame_pending  <= 1'b0;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                lcdmts_pkg::REG_LCD_ENABLE:
                begin
                    // switching the display off parks the sequencer
                    if (cfg_reg.enable && !cfg_data[0])
                    begin
                        st_reg.line          <= 8'd0;
                        st_reg.mode          <= lcdmts_pkg::MODE_HBLANK;
                        st_reg.accum         <= '0;
                        st_reg.frame_pending <= 1'b0;
                    end
                    cfg_reg.enable <= cfg_data[0];
                end
                lcdmts_pkg::REG_LINE_COMPARE:  cfg_reg.line_compare  <= cfg_data[7:0];
                lcdmts_pkg::REG_STAT_ENABLES:  cfg_reg.stat_enables  <= cfg_data[3:0];
                lcdmts_pkg::REG_OAM_CYCLES:    cfg_reg.oam_cycles    <= cfg_data;
                lcdmts_pkg::REG_DRAW_CYCLES:   cfg_reg.draw_cycles   <= cfg_data;
                lcdmts_pkg::REG_HBLANK_CYCLES: cfg_reg.hblank_cycles <= cfg_data;
                lcdmts_pkg::REG_LINE_CYCLES:   cfg_reg.line_cycles   <= cfg_data;
                default:
                begin
                end
            endcase
        end
        else if (in_xfer)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // payload holds until the next transfer in
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !cfg_reg.enable |=> m_tdata[14:11] == 4'd0)
        else $error("flags raised on a tick while the display is off");

    a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> m_tdata[1:0] == lcdmts_pkg::MODE_VBLANK)
        else $error("vblank_irq without vertical blank mode");

    a_rendered_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> m_tdata[1:0] == lcdmts_pkg::MODE_HBLANK)
        else $error("line_rendered without horizontal blank mode");

    a_frame_new_vblank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[11])
        else $error("new frame flag without vertical blank entry");

    a_visible_line: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.mode == lcdmts_pkg::MODE_OAM || st_reg.mode == lcdmts_pkg::MODE_DRAW
        |-> {1'b0, st_reg.line} < VIS_LINES)
        else $error("OAM scan or draw outside the visible lines");
`endif

endmodule

`default_nettype wire

### sv/lcdmts_step.sv
// Next-state and result logic for one tick of the LCD mode timing sequencer.
// Depends on lcdmts_pkg.
`default_nettype none

module lcdmts_step #(
    parameter int VISIBLE_LINES = lcdmts_pkg::VISIBLE_LINES_DEF,
    parameter int TOTAL_LINES   = lcdmts_pkg::TOTAL_LINES_DEF
) (
    input  wire lcdmts_pkg::state_t  st,
    input  wire lcdmts_pkg::cfg_t    cfg,
    input  wire logic [7:0]          cycles,
    input  wire logic                frame_ack,
    output lcdmts_pkg::state_t       st_next,
    output lcdmts_pkg::result_t      res
);

    localparam logic [8:0] VIS_LINES = 9'(VISIBLE_LINES);
    localparam logic [8:0] TOT_LINES = 9'(TOTAL_LINES);

    logic [lcdmts_pkg::ACCUM_W:0]     sum;
    logic [lcdmts_pkg::ACCUM_W-1:0]   acc;
    logic [lcdmts_pkg::THR_W-1:0]     thr;
    logic [8:0]                       next_line;
    logic                             leave;
    logic                             cond;

    always_comb
    begin
        sum       = {1'b0, st.accum} + {{(lcdmts_pkg::ACCUM_W - 7){1'b0}}, cycles};
        acc       = sum[lcdmts_pkg::ACCUM_W] ? lcdmts_pkg::ACCUM_MAX
                                             : sum[lcdmts_pkg::ACCUM_W-1:0];
        next_line = {1'b0, st.line} + 9'd1;

        case (st.mode)
            lcdmts_pkg::MODE_OAM:    thr = cfg.oam_cycles;
            lcdmts_pkg::MODE_DRAW:   thr = cfg.draw_cycles;
            lcdmts_pkg::MODE_HBLANK: thr = cfg.hblank_cycles;
            default:                 thr = cfg.line_cycles;
        endcase
        leave = acc >= {1'b0, thr};

        st_next           = st;
        res.vblank_irq    = 1'b0;
        res.stat_irq      = 1'b0;
        res.frame_new     = 1'b0;
        res.line_rendered = 1'b0;
        cond              = 1'b0;

        // acknowledge lands before the tick, also while the display is off
        if (frame_ack)
            st_next.frame_pending = 1'b0;

        if (cfg.enable)
        begin
            st_next.accum = leave ? acc - {1'b0, thr} : acc;
            if (leave)
            begin
                case (st.mode)
                    lcdmts_pkg::MODE_OAM:
                    begin
                        st_next.mode = lcdmts_pkg::MODE_DRAW;
                    end
                    lcdmts_pkg::MODE_DRAW:
                    begin
                        st_next.mode      = lcdmts_pkg::MODE_HBLANK;
                        res.line_rendered = 1'b1;
                    end
                    lcdmts_pkg::MODE_HBLANK:
                    begin
                        st_next.line = next_line[7:0];
                        if (next_line >= VIS_LINES)
                        begin
                            st_next.mode   = lcdmts_pkg::MODE_VBLANK;
                            res.vblank_irq = 1'b1;
                            if (!st_next.frame_pending)
                            begin
                                st_next.frame_pending = 1'b1;
                                res.frame_new         = 1'b1;
                            end
                        end
                        else
                        begin
                            st_next.mode = lcdmts_pkg::MODE_OAM;
                        end
                    end
                    default:
                    begin
                        if (next_line >= TOT_LINES)
                        begin
                            st_next.line = 8'd0;
                            st_next.mode = lcdmts_pkg::MODE_OAM;
                        end
                        else
                        begin
                            st_next.line = next_line[7:0];
                        end
                    end
                endcase
            end

            // sample the combined status condition after the update
            cond = (cfg.stat_enables[lcdmts_pkg::STAT_HBLANK]
                        && st_next.mode == lcdmts_pkg::MODE_HBLANK)
                || (cfg.stat_enables[lcdmts_pkg::STAT_VBLANK]
                        && st_next.mode == lcdmts_pkg::MODE_VBLANK)
                || (cfg.stat_enables[lcdmts_pkg::STAT_OAM]
                        && st_next.mode == lcdmts_pkg::MODE_OAM)
                || (cfg.stat_enables[lcdmts_pkg::STAT_MATCH]
                        && st_next.line == cfg.line_compare);
            res.stat_irq      = cond && !st.irq_level;
            st_next.irq_level = cond;
        end

        res.mode       = st_next.mode;
        res.line       = st_next.line;
        res.line_match = st_next.line == cfg.line_compare;
    end

endmodule

`default_nettype wire
